FILE: hw/rtl/alpha_beta_tracking_filter_top_macros.svh
// Assertion macros for the alpha-beta tracking filter.
// Needs nothing else; included by the files that carry assertions.
`ifndef ALPHA_BETA_TRACKING_FILTER_TOP_MACROS_SVH
`define ALPHA_BETA_TRACKING_FILTER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ABF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define ABF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/abf_pkg.sv
// Shared types and constants for the alpha-beta tracking filter.
// No dependencies; used by the serial units and the top level.
package abf_pkg;

	// Status of a bit-serial unit: busy while stepping, done for one cycle after
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Operation codes on the mode field
	localparam logic [1:0] MODE_UPDATE  = 2'd0;
	localparam logic [1:0] MODE_PREDICT = 2'd1;
	localparam logic [1:0] MODE_RESET   = 2'd2;

	// Configuration register indexes
	localparam logic [0:0] CFG_ALPHA = 1'b0;
	localparam logic [0:0] CFG_BETA  = 1'b1;

	// Field and datapath widths
	localparam int POS_W     = 32;
	localparam int VEL_W     = 48;
	localparam int DT_W      = 16;
	localparam int GAIN_W    = 17;
	localparam int DT_FRAC   = 16;
	localparam int GAIN_FRAC = 16;
	localparam int PROD_W    = VEL_W + DT_W;          // v * dt
	localparam int RND_W     = PROD_W - DT_FRAC;      // rounded v * dt
	localparam int RES_W     = POS_W + 1;             // residual
	localparam int GPROD_W   = RES_W + GAIN_W;        // gain * residual
	localparam int CORR_W    = GPROD_W - GAIN_FRAC;   // rounded alpha * residual
	localparam int MAG_W     = POS_W + GAIN_FRAC;     // |beta * residual|
	localparam int NUM_W     = MAG_W + 1;             // dividend with rounding term
	localparam int DQ_W      = NUM_W + 1;             // signed velocity step
	localparam int PSUM_W    = 50;                    // position sums before clamping
	localparam int VSUM_W    = DQ_W + 1;              // velocity sum before clamping
	localparam int CFG_W     = GAIN_W;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] ALPHA_RST = GAIN_W'(32768);
	localparam logic [GAIN_W-1:0] BETA_RST  = GAIN_W'(16384);

endpackage

FILE: hw/rtl/abf_ser_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
// One multiplier bit per cycle, LSB first; uses abf_pkg for its status type.
module abf_ser_mul #(
	parameter int A_WIDTH = 48,
	parameter int B_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [A_WIDTH-1:0]          mcand,
	input  logic [B_WIDTH-1:0]          mplier,
	output logic [A_WIDTH+B_WIDTH-1:0]  product,
	output abf_pkg::unit_stat_t         stat
);

	localparam int P_W   = A_WIDTH + B_WIDTH;
	localparam int CNT_W = $clog2(B_WIDTH + 1);

	logic [P_W-1:0]     acc_q;
	logic [A_WIDTH-1:0] mcand_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [A_WIDTH:0]   sum;

	// upper A_WIDTH bits plus multiplicand when the current multiplier bit is set
	always_comb begin
		sum = {acc_q[P_W-1], acc_q[P_W-1:B_WIDTH]}
			+ (acc_q[0] ? {mcand_q[A_WIDTH-1], mcand_q} : {(A_WIDTH+1){1'b0}});
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(B_WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulator: product grows in the top, multiplier bits shift out the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= {{A_WIDTH{1'b0}}, mplier};
			mcand_q <= mcand;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[B_WIDTH-1:1]};
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/abf_ser_div.sv
// Restoring radix-2 divider, unsigned, one quotient bit per cycle.
// Uses abf_pkg for its status type. Divisor must be non-zero.
module abf_ser_div #(
	parameter int N_WIDTH = 49,
	parameter int D_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [N_WIDTH-1:0]   numer,
	input  logic [D_WIDTH-1:0]   denom,
	output logic [N_WIDTH-1:0]   quot,
	output abf_pkg::unit_stat_t  stat
);

	localparam int CNT_W = $clog2(N_WIDTH + 1);

	logic [D_WIDTH-1:0] rem_q;
	logic [N_WIDTH-1:0] quo_q;
	logic [D_WIDTH-1:0] den_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [D_WIDTH:0]   shifted;
	logic [D_WIDTH:0]   diff;
	logic               ge;

	// one trial subtract per cycle
	always_comb begin
		shifted = {rem_q, quo_q[N_WIDTH-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(N_WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_WIDTH-1:0] : shifted[D_WIDTH-1:0];
			quo_q <= {quo_q[N_WIDTH-2:0], ge};
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/alpha_beta_tracking_filter_top.sv
// Alpha-beta tracking filter, top level: control sequencer, state and clamping.
// Depends on abf_pkg, abf_ser_mul, abf_ser_div and the assertion macro header.
//
// Input channel: in_valid/in_stall with mode, sample_value (Q16.16) and
// time_step (Q0.16 s). A word is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with estimate and is_initialized; one
// result word for every input word, in order.
// Configuration: cfg_write with cfg_index (0 alpha, 1 beta) and cfg_data;
// write only while the filter is idle.
// Timing: reset and the first update after reset take 2 cycles per word;
// predict takes 20 (16 for the bit-serial v*dt multiply); a tracked update
// takes about 92: 16 for v*dt, 17 for the two gain multiplies run side by
// side, and 49 for the bit-serial divide by dt, which dominates.
// One word is in flight at a time; in_stall is high from acceptance until
// the result has moved into the output register.
// The output register holds one finished result, so the next word is taken
// while the receiver stalls; a second result waits in the sequencer until
// the output register is free.
// Reset clears position, velocity and the initialised flag, loads the
// default gains, and leaves the output channel empty.
`include "alpha_beta_tracking_filter_top_macros.svh"

module alpha_beta_tracking_filter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic signed [abf_pkg::POS_W-1:0] sample_value,
	input  logic [abf_pkg::DT_W-1:0]         time_step,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [abf_pkg::POS_W-1:0] estimate,
	output logic                             is_initialized,
	input  logic                             cfg_write,
	input  logic [0:0]                       cfg_index,
	input  logic [abf_pkg::CFG_W-1:0]        cfg_data
);

	localparam int POS_W   = abf_pkg::POS_W;
	localparam int VEL_W   = abf_pkg::VEL_W;
	localparam int DT_W    = abf_pkg::DT_W;
	localparam int GAIN_W  = abf_pkg::GAIN_W;
	localparam int PROD_W  = abf_pkg::PROD_W;
	localparam int RND_W   = abf_pkg::RND_W;
	localparam int RES_W   = abf_pkg::RES_W;
	localparam int GPROD_W = abf_pkg::GPROD_W;
	localparam int CORR_W  = abf_pkg::CORR_W;
	localparam int MAG_W   = abf_pkg::MAG_W;
	localparam int NUM_W   = abf_pkg::NUM_W;
	localparam int DQ_W    = abf_pkg::DQ_W;
	localparam int PSUM_W  = abf_pkg::PSUM_W;
	localparam int VSUM_W  = abf_pkg::VSUM_W;

	localparam logic [PROD_W-1:0]  HALF_DT   = PROD_W'(1) << (abf_pkg::DT_FRAC - 1);
	localparam logic [GPROD_W-1:0] HALF_GAIN = GPROD_W'(1) << (abf_pkg::GAIN_FRAC - 1);
	localparam logic [POS_W-1:0]   POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0]   POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [VEL_W-1:0]   VEL_MAX   = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0]   VEL_MIN   = {1'b1, {(VEL_W-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULV,
		S_PRED,
		S_RES,
		S_GMUL,
		S_CORR,
		S_DIVS,
		S_DIV,
		S_VEL,
		S_DONE
	} state_t;

	// clamp a wide position sum to the signed position range
	function automatic logic [POS_W-1:0] sat_pos(input logic [PSUM_W-1:0] a);
		logic [POS_W-1:0] r;
		if (a[PSUM_W-1:POS_W-1] == {(PSUM_W-POS_W+1){a[PSUM_W-1]}}) begin
			r = a[POS_W-1:0];
		end else begin
			r = a[PSUM_W-1] ? POS_MIN : POS_MAX;
		end
		return r;
	endfunction

	// clamp a wide velocity sum to the signed velocity range
	function automatic logic [VEL_W-1:0] sat_vel(input logic [VSUM_W-1:0] a);
		logic [VEL_W-1:0] r;
		if (a[VSUM_W-1:VEL_W-1] == {(VSUM_W-VEL_W+1){a[VSUM_W-1]}}) begin
			r = a[VEL_W-1:0];
		end else begin
			r = a[VSUM_W-1] ? VEL_MIN : VEL_MAX;
		end
		return r;
	endfunction

	state_t             state_q;
	logic [1:0]         mode_q;
	logic [POS_W-1:0]   meas_q;
	logic [DT_W-1:0]    dt_q;
	logic [POS_W-1:0]   x_q;
	logic [VEL_W-1:0]   v_q;
	logic               started_q;
	logic [RND_W-1:0]   rnd_q;
	logic [POS_W-1:0]   pred_q;
	logic [CORR_W-1:0]  corr_q;
	logic [GPROD_W-1:0] n_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [DQ_W-1:0]    dq_q;
	logic [POS_W-1:0]   res_q;
	logic               out_valid_q;
	logic [POS_W-1:0]   estimate_q;
	logic               is_init_q;
	logic [GAIN_W-1:0]  alpha_q;
	logic [GAIN_W-1:0]  beta_q;

	logic               in_acc;
	logic               need_pred;
	logic               mulv_start;
	logic               gain_start;
	logic               div_start;
	logic               out_load;
	logic [GAIN_W-1:0]  alpha_eff;
	logic [GAIN_W-1:0]  beta_eff;
	logic [RES_W-1:0]   resid;
	logic [PROD_W-1:0]  mulv_prod;
	logic [PROD_W-1:0]  mulv_rnd;
	logic [GPROD_W-1:0] mula_prod;
	logic [GPROD_W-1:0] mula_rnd;
	logic [GPROD_W-1:0] mulb_prod;
	logic [GPROD_W-1:0] n_abs;
	logic [NUM_W-1:0]   div_num;
	logic [NUM_W-1:0]   div_quot;
	logic [PSUM_W-1:0]  pred_sum;
	logic [PSUM_W-1:0]  corr_sum;
	logic [VSUM_W-1:0]  vel_sum;
	logic [POS_W-1:0]   pred_sat;
	logic [POS_W-1:0]   corr_sat;

	abf_pkg::unit_stat_t mulv_stat;
	abf_pkg::unit_stat_t mula_stat;
	abf_pkg::unit_stat_t mulb_stat;
	abf_pkg::unit_stat_t div_stat;

	// handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign estimate  = estimate_q;
	assign is_initialized = is_init_q;

	// every mode but reset and a first update needs the prediction
	assign need_pred  = !(mode == abf_pkg::MODE_RESET)
		&& !((mode == abf_pkg::MODE_UPDATE) && !started_q);
	assign mulv_start = in_acc && need_pred;
	assign gain_start = (state_q == S_RES);
	assign div_start  = (state_q == S_DIVS);

	// gains above one count as one
	assign alpha_eff = (alpha_q > abf_pkg::GAIN_ONE) ? abf_pkg::GAIN_ONE : alpha_q;
	assign beta_eff  = (beta_q > abf_pkg::GAIN_ONE) ? abf_pkg::GAIN_ONE : beta_q;

	// datapath arithmetic; each state registers the sums it needs
	always_comb begin
		resid    = {meas_q[POS_W-1], meas_q} - {pred_q[POS_W-1], pred_q};
		mulv_rnd = mulv_prod + HALF_DT;
		mula_rnd = mula_prod + HALF_GAIN;
		n_abs    = n_q[GPROD_W-1] ? (GPROD_W'(0) - n_q) : n_q;
		div_num  = {1'b0, mag_q} + NUM_W'(dt_q >> 1);
		pred_sum = {{(PSUM_W-RND_W){rnd_q[RND_W-1]}}, rnd_q}
			+ {{(PSUM_W-POS_W){x_q[POS_W-1]}}, x_q};
		corr_sum = {{(PSUM_W-CORR_W){corr_q[CORR_W-1]}}, corr_q}
			+ {{(PSUM_W-POS_W){pred_q[POS_W-1]}}, pred_q};
		vel_sum  = {{(VSUM_W-VEL_W){v_q[VEL_W-1]}}, v_q} + {dq_q[DQ_W-1], dq_q};
		pred_sat = sat_pos(pred_sum);
		corr_sat = sat_pos(corr_sum);
	end

	// v * dt
	abf_ser_mul #(
		.A_WIDTH (VEL_W),
		.B_WIDTH (DT_W)
	) u_mulv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mulv_start),
		.mcand   (v_q),
		.mplier  (time_step),
		.product (mulv_prod),
		.stat    (mulv_stat)
	);

	// alpha * residual
	abf_ser_mul #(
		.A_WIDTH (RES_W),
		.B_WIDTH (GAIN_W)
	) u_mula (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gain_start),
		.mcand   (resid),
		.mplier  (alpha_eff),
		.product (mula_prod),
		.stat    (mula_stat)
	);

	// beta * residual
	abf_ser_mul #(
		.A_WIDTH (RES_W),
		.B_WIDTH (GAIN_W)
	) u_mulb (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gain_start),
		.mcand   (resid),
		.mplier  (beta_eff),
		.product (mulb_prod),
		.stat    (mulb_stat)
	);

	// |beta * residual| / dt, rounded half away from zero
	abf_ser_div #(
		.N_WIDTH (NUM_W),
		.D_WIDTH (DT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (dt_q),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= abf_pkg::ALPHA_RST;
			beta_q  <= abf_pkg::BETA_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				abf_pkg::CFG_ALPHA: alpha_q <= cfg_data;
				abf_pkg::CFG_BETA:  beta_q  <= cfg_data;
				default:            alpha_q <= alpha_q;
			endcase
		end
	end

	// sequencer, filter state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= '0;
			meas_q      <= '0;
			dt_q        <= '0;
			x_q         <= '0;
			v_q         <= '0;
			started_q   <= 1'b0;
			rnd_q       <= '0;
			pred_q      <= '0;
			corr_q      <= '0;
			n_q         <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			dq_q        <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			estimate_q  <= '0;
			is_init_q   <= 1'b0;
		end else begin
			// output register: filled by a finished word, emptied once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q <= mode;
						meas_q <= sample_value;
						dt_q   <= time_step;
						if (need_pred) begin
							state_q <= S_MULV;
						end else begin
							// reset, or first measurement after reset
							x_q       <= sample_value;
							v_q       <= '0;
							started_q <= (mode == abf_pkg::MODE_UPDATE);
							res_q     <= sample_value;
							state_q   <= S_DONE;
						end
					end
				end
				S_MULV: begin
					if (mulv_stat.done) begin
						rnd_q   <= mulv_rnd[PROD_W-1:abf_pkg::DT_FRAC];
						state_q <= S_PRED;
					end
				end
				S_PRED: begin
					pred_q <= pred_sat;
					res_q  <= pred_sat;
					if (mode_q == abf_pkg::MODE_UPDATE) begin
						state_q <= S_RES;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RES: begin
					state_q <= S_GMUL;
				end
				S_GMUL: begin
					if (mula_stat.done) begin
						corr_q  <= mula_rnd[GPROD_W-1:abf_pkg::GAIN_FRAC];
						n_q     <= mulb_prod;
						state_q <= S_CORR;
					end
				end
				S_CORR: begin
					x_q   <= corr_sat;
					res_q <= corr_sat;
					mag_q <= n_abs[MAG_W-1:0];
					neg_q <= n_q[GPROD_W-1];
					// zero dt keeps the velocity
					if (dt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIVS;
					end
				end
				S_DIVS: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						dq_q    <= neg_q ? (DQ_W'(0) - {1'b0, div_quot}) : {1'b0, div_quot};
						state_q <= S_VEL;
					end
				end
				S_VEL: begin
					v_q     <= sat_vel(vel_sum);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						estimate_q  <= res_q;
						is_init_q   <= started_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks on the sequencer
	`ABF_ASSERT_NOW(a_mulv_free, clk, arst_n, mulv_start, !mulv_stat.busy,
		"v*dt multiplier restarted while busy")
	`ABF_ASSERT_NOW(a_div_dt_nonzero, clk, arst_n, div_start, dt_q != '0,
		"divide started with zero dt")
	`ABF_ASSERT_NEXT(a_reset_loads, clk, arst_n, in_acc && mode == abf_pkg::MODE_RESET,
		!started_q && v_q == '0 && x_q == $past(sample_value), "reset word did not load state")
	`ABF_ASSERT_NOW(a_done_quiet, clk, arst_n, state_q == S_DONE,
		!(mulv_stat.busy || mula_stat.busy || mulb_stat.busy || div_stat.busy),
		"serial unit still busy at result")

endmodule
